FILE: rtl/cnms_pkg.sv
// shared types and constants for canny non-maximum suppression
package cnms_pkg;
  localparam int MaxWidth = 1024;
  localparam int MaxHeight = 1024;
  localparam int ColW = $clog2(MaxWidth);
  localparam int RowW = $clog2(MaxHeight);
  localparam int MagW = 11;
  localparam int GradW = 11;
  localparam int QDepth = 4;
  localparam int QAw = 2;

  localparam logic [0:0] RegFrameWidth = 1'b0;
  localparam logic [0:0] RegFrameHeight = 1'b1;

  typedef enum logic [1:0] {
    DIR_HORZ = 2'd0,
    DIR_DIAG_DOWN = 2'd1,
    DIR_VERT = 2'd2,
    DIR_DIAG_UP = 2'd3
  } dir_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [MagW-1:0] mag;
    dir_t dir;
    logic [ColW-1:0] col;
    logic col_ok;
    logic emit;
    logic border;
    logic last;
  } pix_t;
endpackage

FILE: rtl/cnms_if.sv
// valid/ready channel interfaces
interface cnms_grad_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [10:0] grad_x;
  logic signed [10:0] grad_y;
  modport source (output valid, grad_x, grad_y, input ready);
  modport sink (input valid, grad_x, grad_y, output ready);
endinterface

interface cnms_edge_if (input logic clk);
  logic valid;
  logic ready;
  logic [10:0] edge_strength;
  logic frame_end;
  modport source (output valid, edge_strength, frame_end, input ready);
  modport sink (input valid, edge_strength, frame_end, output ready);
endinterface

interface cnms_cfg_if (input logic clk);
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/cnms_ram.sv
// generic single-port ram with registered read
module cnms_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule

FILE: rtl/cnms_front.sv
// front end: magnitude by iterative square root, direction, raster position
module cnms_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [10:0]           grad_x,
  input  logic signed [10:0]           grad_y,
  input  logic [10:0]                  frame_width,
  input  logic [10:0]                  frame_height,
  output logic                         q_valid,
  input  logic                         q_ready,
  output cnms_pkg::pix_t               q_item
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ROOT = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  logic [21:0] rem;
  logic [10:0] root;
  logic [3:0] step;
  cnms_pkg::pix_t item;
  logic [cnms_pkg::ColW:0] col;
  logic [cnms_pkg::RowW:0] row;
  logic [10:0] wlim, hlim;
  logic [10:0] ax, ay;
  logic [20:0] ax_sq, ay_sq;
  logic [19:0] lhs, lo_rhs, hi_rhs;
  cnms_pkg::dir_t dir;
  logic [13:0] trial;
  logic [21:0] trial_w;

  always_comb begin
    wlim = frame_width < 11'd3 ? 11'd3 :
           (frame_width > 11'(cnms_pkg::MaxWidth) ? 11'(cnms_pkg::MaxWidth) : frame_width);
    hlim = frame_height < 11'd3 ? 11'd3 :
           (frame_height > 11'(cnms_pkg::MaxHeight) ? 11'(cnms_pkg::MaxHeight) : frame_height);
    ax = grad_x[10] ? 11'(-grad_x) : 11'(grad_x);
    ay = grad_y[10] ? 11'(-grad_y) : 11'(grad_y);
    ax_sq = 21'(ax * ax);
    ay_sq = 21'(ay * ay);
    lhs = {1'b0, ay, 8'd0};
    lo_rhs = 20'(ax * 11'd106);
    hi_rhs = 20'(ax * 11'd618);
    if (lhs < lo_rhs) begin
      dir = cnms_pkg::DIR_HORZ;
    end else if (lhs >= hi_rhs) begin
      dir = cnms_pkg::DIR_VERT;
    end else if (grad_x[10] == grad_y[10]) begin
      dir = cnms_pkg::DIR_DIAG_DOWN;
    end else begin
      dir = cnms_pkg::DIR_DIAG_UP;
    end
    // one result bit per cycle, restoring method
    trial = {root, 2'b01} | 14'd0;
    trial_w = 22'(trial) << (2 * step);
  end

  assign in_ready = (state == S_IDLE);
  assign q_valid = (state == S_DONE);
  always_comb begin
    q_item = item;
    q_item.mag = root;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      col <= '0;
      row <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            rem <= 22'(ax_sq) + 22'(ay_sq);
            root <= '0;
            step <= 4'd10;
            item.dir <= dir;
            item.col <= col[cnms_pkg::ColW-1:0];
            item.col_ok <= (col < (cnms_pkg::ColW+1)'(cnms_pkg::MaxWidth));
            item.emit <= (row != '0) && (col != '0);
            item.border <= (row <= 1) || (col <= 1);
            item.last <= (11'(row) == hlim - 11'd1) && (11'(col) == wlim - 11'd1);
            item.mag <= '0;
            if (11'(col) + 11'd1 >= wlim) begin
              col <= '0;
              row <= (11'(row) + 11'd1 >= hlim) ? '0 : row + 1'b1;
            end else begin
              col <= col + 1'b1;
            end
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if ((rem >> (2 * step)) >= 22'(trial)) begin
            rem <= rem - trial_w;
            root <= {root[9:0], 1'b1};
          end else begin
            root <= {root[9:0], 1'b0};
          end
          if (step == 4'd0) begin
            state <= S_DONE;
          end else begin
            step <= step - 4'd1;
          end
        end
        S_DONE: begin
          if (q_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/cnms_queue.sv
// short fifo between front and back
module cnms_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cnms_pkg::pix_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output cnms_pkg::pix_t out_item
);
  cnms_pkg::pix_t slots [cnms_pkg::QDepth];
  logic [cnms_pkg::QAw-1:0] wp, rp;
  logic [cnms_pkg::QAw:0] cnt;
  logic push, pop;

  assign in_ready = (cnt != (cnms_pkg::QAw+1)'(cnms_pkg::QDepth));
  assign out_valid = (cnt != '0);
  assign out_item = slots[rp];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= in_item;
    end
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (cnms_pkg::QAw+1)'(push) - (cnms_pkg::QAw+1)'(pop);
    end
  end
endmodule

FILE: rtl/cnms_back.sv
// back end: line stores, 3x3 window and neighbour compare
module cnms_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  cnms_pkg::pix_t q_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [10:0]    edge_strength,
  output logic           frame_end
);
  typedef enum logic [1:0] {
    B_READ = 2'b01,
    B_SHIFT = 2'b10
  } state_t;

  state_t state;
  logic [10:0] win [3][3];
  cnms_pkg::dir_t cdir;
  logic [10:0] om_raw;
  logic [12:0] pv_raw;
  logic [10:0] om;
  logic [12:0] pv;
  logic we;
  logic fire;
  logic [10:0] a, b, m, keep;

  assign om = q_item.col_ok ? om_raw : '0;
  assign pv = q_item.col_ok ? pv_raw : '0;

  assign we = (state == B_SHIFT) && q_item.col_ok;

  cnms_ram #(.Width(11), .Depth(cnms_pkg::MaxWidth)) u_older (
    .clk(clk), .we(we), .addr(q_item.col), .wdata(pv_raw[10:0]),
    .re(state == B_READ), .rdata(om_raw)
  );
  cnms_ram #(.Width(13), .Depth(cnms_pkg::MaxWidth)) u_prev (
    .clk(clk), .we(we), .addr(q_item.col), .wdata({q_item.dir, q_item.mag}),
    .re(state == B_READ), .rdata(pv_raw)
  );

  // compare uses window after this item shifts in
  always_comb begin
    m = win[1][2];
    case (cdir)
      cnms_pkg::DIR_HORZ: begin a = win[1][1]; b = pv[10:0]; end
      cnms_pkg::DIR_DIAG_DOWN: begin a = win[0][1]; b = q_item.mag; end
      cnms_pkg::DIR_VERT: begin a = win[0][2]; b = win[2][2]; end
      default: begin a = om; b = win[2][1]; end
    endcase
    keep = (!q_item.border && m > a && m > b) ? m : '0;
  end

  assign fire = (state == B_SHIFT) && (!out_valid || out_ready);
  assign q_ready = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_READ;
      out_valid <= 1'b0;
      cdir <= cnms_pkg::DIR_HORZ;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else begin
      if (fire && q_item.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_READ: begin
          if (q_valid) state <= B_SHIFT;
        end
        B_SHIFT: begin
          if (fire) begin
            for (int i = 0; i < 3; i++) begin
              win[i][0] <= win[i][1];
              win[i][1] <= win[i][2];
            end
            win[0][2] <= om;
            win[1][2] <= pv[10:0];
            win[2][2] <= q_item.mag;
            cdir <= cnms_pkg::dir_t'(pv[12:11]);
            if (q_item.emit) begin
              edge_strength <= keep;
              frame_end <= q_item.last;
            end
            state <= B_READ;
          end
        end
        default: state <= B_READ;
      endcase
    end
  end
endmodule

FILE: rtl/canny_nonmax_suppression.sv
// top level of canny non-maximum suppression
// Takes Sobel gradient pairs in raster order and returns, one row and one column
// behind, the magnitude of each centre pixel kept only where it beats both
// neighbours along its quantized direction; borders give zero, and the bottom
// row and right column are not emitted, so a frame gives (height-1)*(width-1)
// items with frame_end on the last. The front takes a pair, runs 11 steps of
// the bit-serial square root of the magnitude and holds the item until it is
// handed over, taking no new pair meanwhile; the back reads its line stores and
// then shifts, overlapped through a four-entry queue. Line stores hold MaxWidth
// columns; write frame_width and frame_height (index 0 and 1) only while idle.
module canny_nonmax_suppression (
  input logic        clk,
  input logic        rst,
  cnms_grad_if.sink  grad,
  cnms_edge_if.source edges,
  cnms_cfg_if.sink   cfg
);
  logic [10:0] frame_width, frame_height;
  logic f_valid, f_ready, b_valid, b_ready;
  cnms_pkg::pix_t f_item, b_item;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 11'd640;
      frame_height <= 11'd480;
    end else if (cfg.valid) begin
      case (cfg.index)
        cnms_pkg::RegFrameWidth: frame_width <= cfg.data;
        cnms_pkg::RegFrameHeight: frame_height <= cfg.data;
        default: ;
      endcase
    end
  end

  cnms_front u_front (
    .clk(clk), .rst(rst), .in_valid(grad.valid), .in_ready(grad.ready),
    .grad_x(grad.grad_x), .grad_y(grad.grad_y),
    .frame_width(frame_width), .frame_height(frame_height),
    .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
  );

  cnms_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
    .out_valid(b_valid), .out_ready(b_ready), .out_item(b_item)
  );

  cnms_back u_back (
    .clk(clk), .rst(rst), .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
    .out_valid(edges.valid), .out_ready(edges.ready),
    .edge_strength(edges.edge_strength), .frame_end(edges.frame_end)
  );
endmodule
